>>> hdl/sipls_pkg.sv
// shared types and constants for the header list splitter
package sipls_pkg;

  localparam int MAX_VALUE_LEN_DEF = 4096;

  localparam int TOK_START_W = 12;
  localparam int TOK_LEN_W   = 13;
  localparam int STATUS_W    = 3;
  localparam int CHAR_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_PAR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW_EMPTY = 2'd2;

  // special bytes
  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2c;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5c;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [CHAR_W-1:0] CH_LANGLE = 8'h3c;
  localparam logic [CHAR_W-1:0] CH_RANGLE = 8'h3e;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NESTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_STRAY  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNBAL  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BADSEP = 3'd5;
  localparam logic [STATUS_W-1:0] ST_OVF    = 3'd6;

  typedef struct packed {
    logic [CHAR_W-1:0] separator_char;
    logic              ignore_parens;
    logic              allow_empty_last;
  } cfg_t;

  typedef struct packed {
    logic [TOK_START_W-1:0] token_start;
    logic [TOK_LEN_W-1:0]   token_length;
    logic [STATUS_W-1:0]    status;
    logic                   final_token;
  } result_t;

  // up to two results produced by one byte, first one in r0
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

>>> hdl/sipls_core.sv
// byte stage register, quote/bracket tracking and token/fault generation
module sipls_core #(
  parameter int MAX_VALUE_LEN = sipls_pkg::MAX_VALUE_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  sipls_pkg::cfg_t                  cfg,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [sipls_pkg::CHAR_W-1:0]     s_tdata,
  input  logic                             s_tlast,
  input  logic [sipls_pkg::FIFO_CW-1:0]    q_count,
  output sipls_pkg::push_t                 push
);
  import sipls_pkg::*;

  localparam int PW = $clog2(MAX_VALUE_LEN + 1);

  logic              stg_valid;
  logic [CHAR_W-1:0] stg_char;
  logic              stg_last;

  logic          esc, in_q, in_a, in_p, parity, discard;
  logic [PW-1:0] pos, tstart;

  logic          esc_next, in_q_next, in_a_next, in_p_next, parity_next, discard_next;
  logic [PW-1:0] pos_next, tstart_next;

  logic          m_esc, m_q, m_a, m_p, m_par;
  logic [PW-1:0] m_pos, m_ts;
  logic          bad_sep, sep_hit, fault_hit, fin_now, end_val;
  logic [STATUS_W-1:0] fault_code;
  logic [PW-1:0] fin_len, sep_len;
  logic [PW+TOK_START_W-1:0] ts_ext, mts_ext;
  logic [PW+TOK_LEN_W-1:0]   fin_len_ext, sep_len_ext;
  result_t       sep_res, end_res;
  logic [FIFO_CW:0] fill;

  // room for two more results behind whatever the stage may still push
  assign fill = {1'b0, q_count} + (stg_valid ? (FIFO_CW+1)'(2) : '0);
  assign s_tready = (fill <= (FIFO_CW+1)'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else begin
      stg_valid <= s_tvalid && s_tready;
    end
    if (s_tvalid && s_tready) begin
      stg_char <= s_tdata;
      stg_last <= s_tlast;
    end
  end

  always_comb begin
    m_esc      = esc;
    m_q        = in_q;
    m_a        = in_a;
    m_p        = in_p;
    m_par      = parity;
    m_pos      = pos;
    m_ts       = tstart;
    sep_hit    = 1'b0;
    fault_hit  = 1'b0;
    fault_code = ST_OK;
    fin_now    = 1'b0;
    bad_sep = (cfg.separator_char == CH_BSLASH) || (cfg.separator_char == CH_QUOTE) ||
              (cfg.separator_char == CH_LANGLE) || (cfg.separator_char == CH_RANGLE) ||
              (!cfg.ignore_parens && ((cfg.separator_char == CH_LPAREN) ||
                                      (cfg.separator_char == CH_RPAREN)));
    if (stg_valid && !discard) begin
      if (bad_sep) begin
        fault_hit  = 1'b1;
        fault_code = ST_BADSEP;
      end else if (stg_char == CH_NUL) begin
        fin_now = 1'b1;
      end else if (pos >= PW'(MAX_VALUE_LEN)) begin
        fault_hit  = 1'b1;
        fault_code = ST_OVF;
      end else begin
        m_pos = pos + 1'b1;
        case (stg_char) inside
          CH_BSLASH: begin
            m_esc = !esc;
          end
          CH_QUOTE: begin
            if (!esc) m_q = !in_q;
            m_esc = 1'b0;
          end
          CH_LANGLE: begin
            if (!in_q) begin
              if (in_a) begin
                fault_hit  = 1'b1;
                fault_code = ST_NESTED;
              end else begin
                m_a = 1'b1;
              end
            end
            m_esc = 1'b0;
          end
          CH_RANGLE: begin
            if (!in_q) begin
              if (!in_a) begin
                fault_hit  = 1'b1;
                fault_code = ST_STRAY;
              end else begin
                m_a = 1'b0;
              end
            end
            m_esc = 1'b0;
          end
          CH_LPAREN, CH_RPAREN: begin
            if (!in_q) begin
              m_p   = (stg_char == CH_LPAREN);
              m_par = !parity;
            end
            m_esc = 1'b0;
          end
          default: begin
            if (stg_char == cfg.separator_char && !in_q && !in_a &&
                !(in_p && !cfg.ignore_parens)) begin
              sep_hit = 1'b1;
              m_ts    = m_pos;
            end
            m_esc = 1'b0;
          end
        endcase
        fin_now = stg_last && !fault_hit;
      end
      // end of value: balance check before the last token
      if (fin_now) begin
        if (m_q || m_a || (!cfg.ignore_parens && m_par)) begin
          fault_hit  = 1'b1;
          fault_code = ST_UNBAL;
        end else if (m_pos == m_ts && !cfg.allow_empty_last) begin
          fault_hit  = 1'b1;
          fault_code = ST_EMPTY;
        end
      end
    end
  end

  assign fin_len     = m_pos - m_ts;
  assign sep_len     = m_pos - tstart - 1'b1;
  assign ts_ext      = {{TOK_START_W{1'b0}}, tstart};
  assign mts_ext     = {{TOK_START_W{1'b0}}, m_ts};
  assign fin_len_ext = {{TOK_LEN_W{1'b0}}, fin_len};
  assign sep_len_ext = {{TOK_LEN_W{1'b0}}, sep_len};
  assign end_val     = fault_hit || fin_now;

  always_comb begin
    sep_res.token_start  = ts_ext[TOK_START_W-1:0];
    sep_res.token_length = sep_len_ext[TOK_LEN_W-1:0];
    sep_res.status       = ST_OK;
    sep_res.final_token  = 1'b0;
    end_res.final_token  = 1'b1;
    if (fault_hit) begin
      end_res.token_start  = '0;
      end_res.token_length = '0;
      end_res.status       = fault_code;
    end else begin
      // empty last token reads as a bare end marker
      end_res.token_start  = (fin_len == '0) ? '0 : mts_ext[TOK_START_W-1:0];
      end_res.token_length = fin_len_ext[TOK_LEN_W-1:0];
      end_res.status       = ST_OK;
    end
    push.count = {1'b0, sep_hit} + {1'b0, end_val};
    push.r0    = sep_hit ? sep_res : end_res;
    push.r1    = end_res;
  end

  always_comb begin
    esc_next     = esc;
    in_q_next    = in_q;
    in_a_next    = in_a;
    in_p_next    = in_p;
    parity_next  = parity;
    pos_next     = pos;
    tstart_next  = tstart;
    discard_next = discard;
    if (stg_valid) begin
      if (discard) begin
        if (stg_last) begin
          discard_next = 1'b0;
          esc_next     = 1'b0;
          in_q_next    = 1'b0;
          in_a_next    = 1'b0;
          in_p_next    = 1'b0;
          parity_next  = 1'b0;
          pos_next     = '0;
          tstart_next  = '0;
        end
      end else if (end_val) begin
        discard_next = !stg_last;
        esc_next     = 1'b0;
        in_q_next    = 1'b0;
        in_a_next    = 1'b0;
        in_p_next    = 1'b0;
        parity_next  = 1'b0;
        pos_next     = '0;
        tstart_next  = '0;
      end else begin
        esc_next    = m_esc;
        in_q_next   = m_q;
        in_a_next   = m_a;
        in_p_next   = m_p;
        parity_next = m_par;
        pos_next    = m_pos;
        tstart_next = m_ts;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      esc     <= 1'b0;
      in_q    <= 1'b0;
      in_a    <= 1'b0;
      in_p    <= 1'b0;
      parity  <= 1'b0;
      pos     <= '0;
      tstart  <= '0;
      discard <= 1'b0;
    end else begin
      esc     <= esc_next;
      in_q    <= in_q_next;
      in_a    <= in_a_next;
      in_p    <= in_p_next;
      parity  <= parity_next;
      pos     <= pos_next;
      tstart  <= tstart_next;
      discard <= discard_next;
    end
  end

endmodule

>>> hdl/sipls_fifo.sv
// result queue taking up to two results per cycle and giving one
module sipls_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  sipls_pkg::push_t              push,
  input  logic                          pop,
  output sipls_pkg::result_t            head,
  output logic [sipls_pkg::FIFO_CW-1:0] count
);
  import sipls_pkg::*;

  result_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_AW-1:0] wr_ptr1;

  assign wr_ptr1 = wr_ptr + 1'b1;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr] <= push.r0;
    if (push.count == 2'd2) mem[wr_ptr1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push.count);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + FIFO_CW'(push.count) - FIFO_CW'(pop);
    end
  end

endmodule

>>> hdl/sip_header_list_splitter.sv
// top level of the header list splitter: config registers, core and result queue
//
// header value bytes enter on the s_ channel, one byte per transaction: the byte
// in s_tdata, s_tlast on the final byte of the value. a zero byte also ends the
// value. each token comes out on the m_ channel as one transaction with its
// start offset and length in m_tdata, a status code in m_tuser and m_tlast on
// the last result of the value. a fault gives a single result with zero offset
// and length and a nonzero status, and the rest of the value up to s_tlast is
// dropped without results.
// the cfg channel writes separator, paren handling and empty-last policy; it is
// always ready and is meant to be used while no value is in progress.
// a byte is registered in the byte stage, and its results are written into the result
// queue that feeds m_. one byte per cycle while s_tready is high; the eight-entry
// queue absorbs the two results of a byte with a separator on the final byte. s_tready
// drops when the queue cannot take two more results beyond what the stage may push.
// when the receiver stalls, results wait in the queue and m_tdata holds.
// reset empties the queue, clears all per-value state and loads separator ','.
module sip_header_list_splitter #(
  parameter int MAX_VALUE_LEN = sipls_pkg::MAX_VALUE_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // [7:0] char_in
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [31:0]                      m_tdata,   // [11:0] token_start, [24:12] token_length
  output logic [2:0]                       m_tuser,   // [2:0] status
  output logic                             m_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sipls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sipls_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sipls_pkg::*;

  cfg_t                 cfg;
  push_t                push;
  result_t              head;
  logic [FIFO_CW-1:0]   q_count;
  logic                 pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.separator_char   <= CH_COMMA;
      cfg.ignore_parens    <= 1'b0;
      cfg.allow_empty_last <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SEPARATOR:   cfg.separator_char   <= cfg_data;
        REG_IGNORE_PAR:  cfg.ignore_parens    <= cfg_data[0];
        REG_ALLOW_EMPTY: cfg.allow_empty_last <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sipls_core #(
    .MAX_VALUE_LEN(MAX_VALUE_LEN)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_count  (q_count),
    .push     (push)
  );

  assign pop = m_tvalid && m_tready;

  sipls_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .count (q_count)
  );

  assign m_tvalid = (q_count != '0);
  assign m_tdata  = {{(32 - TOK_LEN_W - TOK_START_W){1'b0}}, head.token_length,
                     head.token_start};
  assign m_tuser  = head.status;
  assign m_tlast  = head.final_token;

endmodule

>>> hdl/sipls_checker.sv
// port-level checks for the header list splitter, bound to the top level
module sipls_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [7:0]                       s_tdata,
  input logic                             s_tlast,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [31:0]                      m_tdata,
  input logic [2:0]                       m_tuser,
  input logic                             m_tlast,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [sipls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [sipls_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sipls_pkg::*;

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("stalled result changed");

  // a fault always closes the value
  a_fault_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_OK) |-> m_tlast)
    else $error("fault without final flag");

  // a fault carries no token
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_OK) |-> (m_tdata == '0))
    else $error("fault with token data");

endmodule

bind sip_header_list_splitter sipls_checker u_sipls_checker (.*);

>>> dv/sip_header_list_splitter_checker.sv
`timescale 1ns / 100ps
// checker for the header list splitter: predicts tokens from the byte stream and compares
module sip_header_list_splitter_checker #(
  parameter int MAX_VALUE_LEN = sipls_pkg::MAX_VALUE_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [7:0]                       s_tdata,
  input  logic                             s_tlast,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [31:0]                      m_tdata,
  input  logic [2:0]                       m_tuser,
  input  logic                             m_tlast,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [sipls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sipls_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                               fail_count,
  output int                               pending,
  output int                               worked_bytes
);
  import sipls_pkg::*;

  localparam int MAX_REPORTS = 20;

  // register copies
  logic [7:0] split_char;
  logic       parens_plain;
  logic       empty_ok;

  // per-value parse state
  logic        esc;
  logic        in_quote;
  logic        in_angle;
  logic        in_paren;
  logic        paren_odd;
  logic        dropping;
  int unsigned pos;
  int unsigned tok_start;

  result_t expected_tokens[$];
  int      fails = 0;
  int      useful = 0;

  initial begin
    fail_count = 0;
    pending = 0;
    worked_bytes = 0;
  end

  task automatic queue_token(input int unsigned start, input int unsigned len,
                             input logic [STATUS_W-1:0] st, input logic fin);
    result_t r;
    r.token_start = start[TOK_START_W-1:0];
    r.token_length = len[TOK_LEN_W-1:0];
    r.status = st;
    r.final_token = fin;
    expected_tokens.push_back(r);
  endtask

  task automatic reset_value_state();
    esc = 1'b0;
    in_quote = 1'b0;
    in_angle = 1'b0;
    in_paren = 1'b0;
    paren_odd = 1'b0;
    dropping = 1'b0;
    pos = 0;
    tok_start = 0;
  endtask

  // a fault is one result; the rest of the value is dropped unless this byte ends it
  task automatic flag_fault(input logic [STATUS_W-1:0] st, input logic last);
    queue_token(0, 0, st, 1'b1);
    reset_value_state();
    dropping = !last;
  endtask

  task automatic close_value(input logic last);
    if (in_quote || in_angle || (!parens_plain && paren_odd)) begin
      flag_fault(ST_UNBAL, last);
      return;
    end
    if (pos == tok_start) begin
      if (!empty_ok) begin
        flag_fault(ST_EMPTY, last);
        return;
      end
      queue_token(0, 0, ST_OK, 1'b1);
    end else begin
      queue_token(tok_start, pos - tok_start, ST_OK, 1'b1);
    end
    reset_value_state();
    dropping = !last;
  endtask

  task automatic tokenize_byte(input logic [7:0] ch, input logic last);
    if (dropping) begin
      if (last)
        reset_value_state();
      return;
    end
    useful++;
    if (split_char == CH_BSLASH || split_char == CH_QUOTE || split_char == CH_LANGLE ||
        split_char == CH_RANGLE ||
        (!parens_plain && (split_char == CH_LPAREN || split_char == CH_RPAREN))) begin
      flag_fault(ST_BADSEP, last);
      return;
    end
    if (ch == CH_NUL) begin
      close_value(last);
      return;
    end
    if (pos >= MAX_VALUE_LEN) begin
      flag_fault(ST_OVF, last);
      return;
    end
    pos++;
    if (ch == CH_BSLASH) begin
      esc = !esc;
    end else begin
      if (ch == CH_QUOTE) begin
        if (!esc)
          in_quote = !in_quote;
      end else if (ch == CH_LANGLE) begin
        if (!in_quote) begin
          if (in_angle) begin
            flag_fault(ST_NESTED, last);
            return;
          end
          in_angle = 1'b1;
        end
      end else if (ch == CH_RANGLE) begin
        if (!in_quote) begin
          if (!in_angle) begin
            flag_fault(ST_STRAY, last);
            return;
          end
          in_angle = 1'b0;
        end
      end else if (ch == CH_LPAREN || ch == CH_RPAREN) begin
        if (!in_quote) begin
          in_paren = (ch == CH_LPAREN);
          paren_odd = !paren_odd;
        end
      end else if (ch == split_char && !in_quote && !in_angle &&
                   !(in_paren && !parens_plain)) begin
        queue_token(tok_start, pos - tok_start - 1, ST_OK, 1'b0);
        tok_start = pos;
      end
      esc = 1'b0;
    end
    if (last)
      close_value(1'b1);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      split_char = CH_COMMA;
      parens_plain = 1'b0;
      empty_ok = 1'b0;
      reset_value_state();
      expected_tokens.delete();
    end else begin
      // results trail their bytes, so compare before predicting this edge's byte
      if (m_tvalid && m_tready) begin
        if (expected_tokens.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t: unexpected result: start %0d len %0d status %0d last %0b",
                     $time, m_tdata[11:0], m_tdata[24:12], m_tuser, m_tlast);
        end else begin
          want = expected_tokens.pop_front();
          if (m_tdata[11:0] !== want.token_start || m_tdata[24:12] !== want.token_length ||
              m_tuser !== want.status || m_tlast !== want.final_token) begin
            fails++;
            if (fails <= MAX_REPORTS)
              $display({"%0t: token mismatch: expected start %0d len %0d status %0d ",
                        "last %0b, got start %0d len %0d status %0d last %0b"},
                       $time, want.token_start, want.token_length, want.status,
                       want.final_token, m_tdata[11:0], m_tdata[24:12], m_tuser, m_tlast);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SEPARATOR:   split_char = cfg_data;
          REG_IGNORE_PAR:  parens_plain = cfg_data[0];
          REG_ALLOW_EMPTY: empty_ok = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        tokenize_byte(s_tdata, s_tlast);
    end
    fail_count <= fails;
    worked_bytes <= useful;
    pending <= expected_tokens.size();
  end

endmodule

>>> dv/sip_header_list_splitter_test.sv
`timescale 1ns / 100ps
// testbench top for the header list splitter: clock, reset, stimulus and verdict
module sip_header_list_splitter_test;
  import sipls_pkg::*;

  localparam int VALUE_LIMIT   = MAX_VALUE_LEN_DEF;
  localparam int IDLE_PCT      = 35;
  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_BYTES   = 160;
  localparam logic [7:0] SPECIALS [6] = '{CH_BSLASH, CH_QUOTE, CH_LANGLE, CH_RANGLE,
                                          CH_LPAREN, CH_RPAREN};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = CH_NUL;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [31:0]           m_tdata;
  logic [2:0]            m_tuser;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_SEPARATOR;
  logic [CFG_DATA_W-1:0] cfg_data = CH_COMMA;

  logic       steady = 1'b0;
  logic [7:0] split_now = CH_COMMA;
  int         fail_count;
  int         pending;
  int         worked_bytes;
  int         quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sip_header_list_splitter #(.MAX_VALUE_LEN(VALUE_LIMIT)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  sip_header_list_splitter_checker #(.MAX_VALUE_LEN(VALUE_LIMIT)) tokens_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .worked_bytes(worked_bytes)
  );

  always @(posedge clk) m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

  // ends the run when no transaction moves on any channel for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] ch, input logic last);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= ch;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_text(input string t);
    int i;
    for (i = 0; i < t.len(); i++)
      send_byte(t[i], i == t.len() - 1);
  endtask

  task automatic send_value_bytes(input logic [7:0] vb[$]);
    int i;
    for (i = 0; i < vb.size(); i++)
      send_byte(vb[i], i == vb.size() - 1);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [7:0] sep, input logic ign, input logic allow);
    write_reg(REG_SEPARATOR, sep);
    write_reg(REG_IGNORE_PAR, {7'd0, ign});
    write_reg(REG_ALLOW_EMPTY, {7'd0, allow});
    cfg_valid <= 1'b0;
    split_now = sep;
  endtask

  // hold the sender until every expected token is back, then let dropped bytes drain
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_letters(ref logic [7:0] vb[$]);
    repeat ($urandom_range(0, 3)) vb.push_back(8'($urandom_range(8'h61, 8'h7a)));
  endtask

  // mostly well-formed lists of tokens, some broken by a stray special byte, some noise
  task automatic send_value();
    logic [7:0] vb[$];
    int         ntok;
    int         pick;
    int         k;
    ntok = $urandom_range(1, 4);
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      repeat ($urandom_range(1, 8)) vb.push_back(8'($urandom_range(0, 255)));
    end else begin
      for (k = 0; k < ntok; k++) begin
        if (k > 0)
          vb.push_back(split_now);
        repeat ($urandom_range(0, 3)) begin
          case ($urandom_range(0, 5))
            0: begin
              vb.push_back(CH_QUOTE);
              add_letters(vb);
              if ($urandom_range(0, 1) == 1)
                vb.push_back(split_now);
              if ($urandom_range(0, 2) == 0) begin
                vb.push_back(CH_BSLASH);
                vb.push_back(CH_QUOTE);
              end
              vb.push_back(CH_QUOTE);
            end
            1: begin
              vb.push_back(CH_LANGLE);
              add_letters(vb);
              vb.push_back(split_now);
              add_letters(vb);
              vb.push_back(CH_RANGLE);
            end
            2: begin
              vb.push_back(CH_LPAREN);
              add_letters(vb);
              vb.push_back(split_now);
              vb.push_back(CH_RPAREN);
            end
            3: begin
              vb.push_back(CH_BSLASH);
              if ($urandom_range(0, 1) == 1)
                vb.push_back(CH_BSLASH);
            end
            default: add_letters(vb);
          endcase
        end
      end
      if (pick < 24)
        vb.insert($urandom_range(0, vb.size()), SPECIALS[$urandom_range(0, 5)]);
      case ($urandom_range(0, 9))
        0: vb.push_back(CH_NUL);
        1: begin
          // early end by a zero byte, the rest is dropped up to tlast
          vb.push_back(CH_NUL);
          add_letters(vb);
          vb.push_back(8'($urandom_range(0, 255)));
        end
        2: vb.push_back(split_now);
        default: ;
      endcase
    end
    if (vb.size() == 0)
      vb.push_back(CH_NUL);
    send_value_bytes(vb);
  endtask

  initial begin
    int         p;
    int         target;
    int         base;
    logic [7:0] sep;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: ',' separator, parens protect, empty last token is an error
    send_text("a,b");
    send_text("\"x\\\",\",y");
    send_text("<<z");
    send_text(">");
    send_text("(a");
    send_text("a,");
    send_byte(8'hff, 1'b0);
    send_byte(CH_NUL, 1'b0);
    send_byte(8'h7f, 1'b1);
    send_byte(CH_NUL, 1'b1);
    settle();
    set_config(CH_LANGLE, 1'b0, 1'b0);
    send_text("a");
    settle();
    set_config(CH_COMMA, 1'b1, 1'b1);
    send_text("(a,");

    for (p = 0; p < 8; p++) begin
      settle();
      case (p)
        0, 5:    sep = CH_COMMA;
        1:       sep = 8'h3b;
        2:       sep = 8'hff;
        3:       sep = CH_RPAREN;
        4:       sep = CH_NUL;
        6:       sep = 8'($urandom_range(0, 255));
        default: sep = CH_QUOTE;
      endcase
      steady = (p == 5);
      set_config(sep, p[0], p[1]);
      target = (p == 7) ? 40 : PHASE_BYTES;
      base = worked_bytes;
      while (worked_bytes - base < target)
        send_value();
    end
    steady = 1'b0;

    settle();
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
